// ===== src/assert_macros.svh =====
// assertion macros shared by the flood / nack repair engine rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`endif

// ===== src/bfnr_pkg.sv =====
// types, codes and constants of the flood / nack repair engine
// no dependencies; imported by every module of the block
`default_nettype none

package bfnr_pkg;

  // protocol constants
  localparam logic [8:0]  CHUNK_BYTES      = 9'd64;
  localparam logic [12:0] TICKS_PER_SECOND = 13'd128;
  localparam logic [15:0] NACK_DELAY       = 16'(TICKS_PER_SECOND / 4);
  localparam logic [15:0] TICK_PERIOD_RST  = 16'd256;

  // command queue depth between front and back
  localparam int CMD_DEPTH_DEF = 4;

  // configuration register index
  localparam logic REG_TICK_PERIOD = 1'b0;

  typedef enum logic [1:0] {
    FUNC_FLOOD  = 2'd0,
    FUNC_POLITE = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_START  = 2'd3
  } func_t;

  typedef enum logic {
    PKT_DATA = 1'b0,
    PKT_NACK = 1'b1
  } pkt_type_t;

  typedef enum logic [2:0] {
    ACT_NEWFILE = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_NACK    = 3'd2,
    ACT_FLOOD   = 3'd3,
    ACT_POLITE  = 3'd4,
    ACT_REARM   = 3'd5
  } action_t;

  // one classified event: up to three actions and the values they carry
  typedef struct packed {
    logic [1:0]        cnt;
    action_t [2:0]     act;
    logic [15:0]       wr_chunk;
    logic [6:0]        wr_len;
    logic              wr_last;
    logic [7:0]        hdr_version;
    logic [15:0]       hdr_chunk;
    logic [15:0]       dly;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/block_flood_nack_repair_engine_core.sv =====
// top level of the flood / nack repair engine: config register, front, queue, back
// depends on bfnr_pkg, bfnr_front, bfnr_cmd_fifo, bfnr_back
// usage
//   input channel: an event transaction is taken when push is high and full is low.
//   in_func selects flooded packet, polite packet, send tick or start transfer.
//   result channel: while empty is low the oldest action sits on the out_ ports;
//   pop with empty low takes it. every event gives zero to three actions, the
//   final one marked by out_last; ignored events give none. config: apb-style port,
//   tick period at byte address 0, pready tied high, write on the access cycle;
//   the user must write it only while the block is idle; the block does not enforce it.
// timing
//   the front classifies an event and updates the protocol state in the cycle
//   it is taken, so events can come back to back while the command queue has room.
//   the back moves one action per cycle into the result register while the
//   receiver keeps up; the first action of an event passes through the command
//   queue and then the result register, and the back expands the actions of
//   an event one after another.
//   a stalled receiver fills the result register, then the command queue, and
//   full then holds off the sender; nothing is dropped.
// reset: synchronous rst_n clears state, queue and result valid flag; tick period 256
`default_nettype none

module block_flood_nack_repair_engine_core #(
  parameter int CMD_DEPTH = bfnr_pkg::CMD_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,

  // input channel
  input  wire logic         push,
  output logic              full,
  input  wire logic [1:0]   in_func,
  input  wire logic         in_pkt_type,
  input  wire logic [7:0]   in_pkt_version,
  input  wire logic [15:0]  in_pkt_chunk,
  input  wire logic [6:0]   in_item_len,

  // result channel
  output logic              empty,
  input  wire logic         pop,
  output logic [2:0]        out_action,
  output logic [21:0]       out_write_offset,
  output logic [6:0]        out_write_len,
  output logic              out_write_last,
  output logic [7:0]        out_out_version,
  output logic [15:0]       out_out_chunk,
  output logic [15:0]       out_send_delay,
  output logic              out_last,

  // configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bfnr_pkg::*;

  // configuration register
  logic [15:0] tick_period_r;
  logic        reg_idx;
  logic        cfg_wr;

  // front to queue to back
  logic        accept;
  logic        cmd_push;
  cmd_t        cmd_in;
  cmd_t        cmd_head;
  logic        cmd_empty;
  logic        cmd_pop;

  assign pready  = 1'b1;
  assign reg_idx = 1'(paddr >> 2);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == REG_TICK_PERIOD) ? {16'd0, tick_period_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= TICK_PERIOD_RST;
    end else if (cfg_wr && reg_idx == REG_TICK_PERIOD) begin
      tick_period_r <= pwdata[15:0];
    end
  end

  // an event is taken whenever the command queue has room
  assign accept = push && !full;

  bfnr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_func        (in_func),
    .in_pkt_type    (in_pkt_type),
    .in_pkt_version (in_pkt_version),
    .in_pkt_chunk   (in_pkt_chunk),
    .in_item_len    (in_item_len),
    .tick_period    (tick_period_r),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  bfnr_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  bfnr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd_head),
    .cmd_empty        (cmd_empty),
    .cmd_pop          (cmd_pop),
    .pop              (pop),
    .empty            (empty),
    .out_action       (out_action),
    .out_write_offset (out_write_offset),
    .out_write_len    (out_write_len),
    .out_write_last   (out_write_last),
    .out_out_version  (out_out_version),
    .out_out_chunk    (out_out_chunk),
    .out_send_delay   (out_send_delay),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// ===== src/bfnr_front.sv =====
// front end: accepts events, keeps protocol state, builds action commands
// depends on bfnr_pkg
`default_nettype none

module bfnr_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [1:0]          in_func,
  input  wire logic                in_pkt_type,
  input  wire logic [7:0]          in_pkt_version,
  input  wire logic [15:0]         in_pkt_chunk,
  input  wire logic [6:0]          in_item_len,
  input  wire logic [15:0]         tick_period,
  output logic                     cmd_push,
  output bfnr_pkg::cmd_t           cmd
);
  import bfnr_pkg::*;

  logic [7:0]  cur_version_r, cur_version_nxt;
  logic [15:0] next_chunk_r, next_chunk_nxt;
  logic [15:0] highest_heard_r, highest_heard_nxt;
  logic        heard_polite_r, heard_polite_nxt;

  logic [7:0]  diff_cv, diff_vc;
  logic        pkt_newer, pkt_older, same_ver, len_full, data_path;
  logic [15:0] hh_w;
  logic [1:0]  n;
  cmd_t        cmd_c;

  assign diff_cv   = cur_version_r - in_pkt_version;
  assign diff_vc   = in_pkt_version - cur_version_r;
  assign pkt_newer = diff_cv[7];
  assign pkt_older = diff_vc[7];
  assign same_ver  = (in_pkt_version == cur_version_r);
  assign len_full  = ({2'b00, in_item_len} >= CHUNK_BYTES);

  always_comb begin
    cur_version_nxt   = cur_version_r;
    next_chunk_nxt    = next_chunk_r;
    highest_heard_nxt = highest_heard_r;
    heard_polite_nxt  = heard_polite_r;
    hh_w              = highest_heard_r;
    data_path         = 1'b0;
    n                 = 2'd0;
    cmd_c             = '0;
    cmd_c.wr_chunk    = in_pkt_chunk;
    cmd_c.wr_len      = in_item_len;
    cmd_c.wr_last     = !len_full;

    case (func_t'(in_func))
      FUNC_FLOOD: begin
        data_path = (pkt_type_t'(in_pkt_type) == PKT_DATA);
      end
      FUNC_POLITE: begin
        heard_polite_nxt = 1'b1;
        if (pkt_type_t'(in_pkt_type) == PKT_NACK) begin
          if (same_ver) begin
            if (in_pkt_chunk < next_chunk_r) begin
              cmd_c.act[n]      = ACT_POLITE;
              cmd_c.hdr_version = cur_version_r;
              cmd_c.hdr_chunk   = in_pkt_chunk;
              cmd_c.dly         = NACK_DELAY;
              n                 = n + 2'd1;
            end
          end else if (pkt_older) begin
            cmd_c.act[n]      = ACT_POLITE;
            cmd_c.hdr_version = cur_version_r;
            cmd_c.hdr_chunk   = 16'd0;
            cmd_c.dly         = tick_period >> 1;
            n                 = n + 2'd1;
          end
        end else begin
          data_path = 1'b1;
        end
      end
      FUNC_TICK: begin
        cmd_c.dly = tick_period;
        if (!heard_polite_r) begin
          cmd_c.act[n]      = ACT_FLOOD;
          cmd_c.hdr_version = cur_version_r;
          cmd_c.hdr_chunk   = next_chunk_r;
          n                 = n + 2'd1;
          if (len_full) begin
            cmd_c.act[n] = ACT_REARM;
            n            = n + 2'd1;
          end
          highest_heard_nxt = next_chunk_r;
          next_chunk_nxt    = next_chunk_r + 16'd1;
        end else begin
          cmd_c.act[n] = ACT_REARM;
          n            = n + 2'd1;
        end
        heard_polite_nxt = 1'b0;
      end
      FUNC_START: begin
        cur_version_nxt   = cur_version_r + 8'd1;
        highest_heard_nxt = 16'd0;
        next_chunk_nxt    = 16'd1;
        cmd_c.act[0]      = ACT_FLOOD;
        cmd_c.act[1]      = ACT_REARM;
        cmd_c.hdr_version = cur_version_r + 8'd1;
        cmd_c.hdr_chunk   = 16'd0;
        cmd_c.dly         = tick_period;
        n                 = 2'd2;
      end
      default: ;
    endcase

    if (data_path) begin
      if (pkt_newer) begin
        // newer transfer: adopt version, restart from chunk 0
        cur_version_nxt   = in_pkt_version;
        highest_heard_nxt = 16'd0;
        next_chunk_nxt    = 16'd0;
        if (in_pkt_chunk != 16'd0) begin
          cmd_c.act[n]      = ACT_NACK;
          cmd_c.hdr_version = in_pkt_version;
          cmd_c.hdr_chunk   = 16'd0;
          n                 = n + 2'd1;
        end else begin
          cmd_c.act[n] = ACT_NEWFILE;
          n            = n + 2'd1;
          cmd_c.act[n] = ACT_WRITE;
          n            = n + 2'd1;
          next_chunk_nxt = 16'd1;
        end
      end else if (same_ver) begin
        if (in_pkt_chunk == next_chunk_r) begin
          if (in_pkt_chunk == 16'd0) begin
            cmd_c.act[n] = ACT_NEWFILE;
            n            = n + 2'd1;
          end
          cmd_c.act[n]   = ACT_WRITE;
          n              = n + 2'd1;
          hh_w           = (highest_heard_r < next_chunk_r) ? next_chunk_r : highest_heard_r;
          next_chunk_nxt = next_chunk_r + 16'd1;
        end else if (in_pkt_chunk > next_chunk_r) begin
          cmd_c.act[n]      = ACT_NACK;
          cmd_c.hdr_version = cur_version_r;
          cmd_c.hdr_chunk   = next_chunk_r;
          n                 = n + 2'd1;
          hh_w              = in_pkt_chunk;
        end
        highest_heard_nxt = hh_w;
        // gap behind a heard chunk: ask for the next expected one
        if (hh_w > in_pkt_chunk) begin
          cmd_c.act[n]      = ACT_NACK;
          cmd_c.hdr_version = cur_version_r;
          cmd_c.hdr_chunk   = next_chunk_nxt;
          n                 = n + 2'd1;
        end
      end
    end

    cmd_c.cnt = n;
  end

  assign cmd      = cmd_c;
  assign cmd_push = accept && (cmd_c.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_version_r   <= '0;
      next_chunk_r    <= '0;
      highest_heard_r <= '0;
      heard_polite_r  <= 1'b0;
    end else if (accept) begin
      cur_version_r   <= cur_version_nxt;
      next_chunk_r    <= next_chunk_nxt;
      highest_heard_r <= highest_heard_nxt;
      heard_polite_r  <= heard_polite_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/bfnr_cmd_fifo.sv =====
// command queue between front end and back end
// depends on bfnr_pkg
`default_nettype none

module bfnr_cmd_fifo #(
  parameter int DEPTH = bfnr_pkg::CMD_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  bfnr_pkg::cmd_t       wr_data,
  output logic                 full,
  input  wire logic            rd_en,
  output bfnr_pkg::cmd_t       rd_data,
  output logic                 empty
);
  import bfnr_pkg::*;
  `include "assert_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `ASSERT_NEVER(a_push_full, clk, rst_n, wr_en && full, "command pushed into full queue")
  `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > CNT_W'(DEPTH), "queue count beyond depth")
  `ASSERT_AT(a_ptr_cnt, clk, rst_n, (cnt_r == '0 || cnt_r == CNT_W'(DEPTH)) |-> (wr_ptr_r == rd_ptr_r), "pointers disagree with count")

endmodule

`default_nettype wire

// ===== src/bfnr_back.sv =====
// back end: expands queued commands into one action per cycle while the receiver keeps up
// depends on bfnr_pkg; holds the result register of the top level channel
`default_nettype none

module bfnr_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  bfnr_pkg::cmd_t     cmd,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [2:0]         out_action,
  output logic [21:0]        out_write_offset,
  output logic [6:0]         out_write_len,
  output logic               out_write_last,
  output logic [7:0]         out_out_version,
  output logic [15:0]        out_out_chunk,
  output logic [15:0]        out_send_delay,
  output logic               out_last
);
  import bfnr_pkg::*;
  `include "assert_macros.svh"

  logic [1:0]  slot_r, slot_nxt;
  logic        valid_r, valid_nxt;
  logic        load, emit, last_slot;
  action_t     act;
  logic [24:0] prod;

  logic [2:0]  action_c;
  logic [21:0] offset_c;
  logic [6:0]  len_c;
  logic        wlast_c;
  logic [7:0]  ver_c;
  logic [15:0] chunk_c, delay_c;

  assign load      = !valid_r || pop;
  assign emit      = !cmd_empty && load;
  assign act       = cmd.act[slot_r];
  assign last_slot = (slot_r == (cmd.cnt - 2'd1));
  assign cmd_pop   = emit && last_slot;
  assign prod      = {9'd0, cmd.wr_chunk} * {16'd0, CHUNK_BYTES};

  always_comb begin
    action_c = act;
    offset_c = '0;
    len_c    = '0;
    wlast_c  = 1'b0;
    ver_c    = '0;
    chunk_c  = '0;
    delay_c  = '0;
    case (act)
      ACT_NEWFILE: ;
      ACT_WRITE: begin
        offset_c = prod[21:0];
        len_c    = cmd.wr_len;
        wlast_c  = cmd.wr_last;
      end
      ACT_NACK: begin
        ver_c   = cmd.hdr_version;
        chunk_c = cmd.hdr_chunk;
        delay_c = NACK_DELAY;
      end
      ACT_FLOOD: begin
        ver_c   = cmd.hdr_version;
        chunk_c = cmd.hdr_chunk;
      end
      ACT_POLITE: begin
        ver_c   = cmd.hdr_version;
        chunk_c = cmd.hdr_chunk;
        delay_c = cmd.dly;
      end
      ACT_REARM: begin
        delay_c = cmd.dly;
      end
      default: ;
    endcase
  end

  always_comb begin
    slot_nxt  = slot_r;
    valid_nxt = valid_r;
    if (emit) begin
      slot_nxt  = last_slot ? 2'd0 : slot_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      slot_r  <= slot_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_action       <= action_c;
      out_write_offset <= offset_c;
      out_write_len    <= len_c;
      out_write_last   <= wlast_c;
      out_out_version  <= ver_c;
      out_out_chunk    <= chunk_c;
      out_send_delay   <= delay_c;
      out_last         <= last_slot;
    end
  end

  assign empty = !valid_r;

  `ASSERT_NEVER(a_slot_range, clk, rst_n, !cmd_empty && (slot_r >= cmd.cnt), "action slot beyond command count")
  `ASSERT_NEVER(a_cnt_zero, clk, rst_n, !cmd_empty && (cmd.cnt == 2'd0), "empty command in queue")
  `ASSERT_AT(a_last_pop, clk, rst_n, cmd_pop |=> (valid_r && out_last), "command retired without last flag")

endmodule

`default_nettype wire
